>>> hdl/twn_pkg.sv
`default_nettype none
package twn_pkg;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BUILD,
		ST_BDRAIN,
		ST_QSCAN,
		ST_QDRAIN,
		ST_RISSUE,
		ST_RS1,
		ST_RS2
	} twn_state_t;

	// Item kinds
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_BUILD = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;
	localparam logic [1:0] KIND_READ  = 2'd3;

	// Result status codes
	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_EMPTY = 2'd1;
	localparam logic [1:0] STS_RANGE = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_COLS = 2'd0;
	localparam logic [1:0] CFG_ROWS = 2'd1;
	localparam logic [1:0] CFG_TILE = 2'd2;

	// Configuration reset values
	localparam logic [5:0] COLS_RST = 6'd32;
	localparam logic [5:0] ROWS_RST = 6'd32;
	localparam logic [7:0] TILE_RST = 8'd32;

endpackage
`default_nettype wire

>>> hdl/twn_solid_map.sv
`default_nettype none
module twn_solid_map #(
	parameter int AW = 10
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic          wr_data,
	input  wire logic [AW-1:0] rd_a_addr,
	input  wire logic [AW-1:0] rd_b_addr,
	output logic               rd_a_data,
	output logic               rd_b_data
);

	localparam int DEPTH = 1 << AW;

	logic mem [DEPTH];

	// Write one cell, read two cells with registered data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_a_data <= mem[rd_a_addr];
		rd_b_data <= mem[rd_b_addr];
	end

endmodule
`default_nettype wire

>>> hdl/twn_node_store.sv
`default_nettype none
module twn_node_store #(
	parameter int AW = 10,
	parameter int EW = 11
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [EW-1:0] wr_data,
	input  wire logic [AW-1:0] rd_a_addr,
	input  wire logic [AW-1:0] rd_b_addr,
	output logic      [EW-1:0] rd_a_data,
	output logic      [EW-1:0] rd_b_data
);

	localparam int DEPTH = 1 << AW;

	logic [EW-1:0] mem [DEPTH];

	// Node entry: column, row, left-link flag
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_a_data <= mem[rd_a_addr];
		rd_b_data <= mem[rd_b_addr];
	end

endmodule
`default_nettype wire

>>> hdl/twn_dist_unit.sv
`default_nettype none
module twn_dist_unit #(
	parameter int CLW = 5,
	parameter int RLW = 5,
	parameter int TW  = 10,
	parameter int SW  = 37
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_last,
	input  wire logic [TW-1:0]      in_tag,
	input  wire logic [CLW-1:0]     in_col,
	input  wire logic [RLW-1:0]     in_row,
	input  wire logic [7:0]         tile_px,
	input  wire logic signed [15:0] qx,
	input  wire logic signed [15:0] qy,
	output logic [CLW-1:0]          col_s2,
	output logic [RLW-1:0]          row_s2,
	output logic [CLW+8:0]          cx_s2,
	output logic [RLW+8:0]          cy_s2,
	output logic                    out_valid,
	output logic                    out_last,
	output logic [TW-1:0]           out_tag,
	output logic [SW-1:0]           out_dist
);

	localparam int CXW = CLW + 9;
	localparam int CYW = RLW + 9;
	localparam int DXW = ((CXW > 16) ? CXW : 16) + 2;
	localparam int DYW = ((CYW > 16) ? CYW : 16) + 2;

	logic                  v_s2, v_s3, v_s4, v_s5;
	logic                  l_s2, l_s3, l_s4, l_s5;
	logic [TW-1:0]         t_s2, t_s3, t_s4, t_s5;
	logic signed [DXW-1:0] dx_s3;
	logic signed [DYW-1:0] dy_s3;
	logic [2*DXW-1:0]      sqx_s4;
	logic [2*DYW-1:0]      sqy_s4;
	logic [SW-1:0]         sum_s5;

	// Advance the valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s2 <= in_valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Centre, offset, square, sum
	always_ff @(posedge clk) begin
		l_s2   <= in_last;
		t_s2   <= in_tag;
		col_s2 <= in_col;
		row_s2 <= in_row;
		cx_s2  <= CXW'({in_col, 1'b1} * tile_px);
		cy_s2  <= CYW'({in_row, 1'b1} * tile_px);
		l_s3   <= l_s2;
		t_s3   <= t_s2;
		dx_s3  <= DXW'($signed({1'b0, cx_s2})) - DXW'(qx);
		dy_s3  <= DYW'($signed({1'b0, cy_s2})) - DYW'(qy);
		l_s4   <= l_s3;
		t_s4   <= t_s3;
		sqx_s4 <= $unsigned((2*DXW)'(dx_s3) * (2*DXW)'(dx_s3));
		sqy_s4 <= $unsigned((2*DYW)'(dy_s3) * (2*DYW)'(dy_s3));
		l_s5   <= l_s4;
		t_s5   <= t_s4;
		sum_s5 <= SW'(sqx_s4) + SW'(sqy_s4);
	end

	assign out_valid = v_s5;
	assign out_last  = l_s5;
	assign out_tag   = t_s5;
	assign out_dist  = sum_s5;

endmodule
`default_nettype wire

>>> hdl/tile_walkable_node_table_nearest_unit.sv
`default_nettype none
// Walkable-node table over a tile collision bitmap. Start an item when busy is low;
// its single result appears on the result ports for one cycle with done high and
// cannot be held off. After reset every bitmap cell is swept clear with busy high;
// configuration writes are taken at any time. A cell write's result follows in the
// next cycle. A build scans one cell per cycle through the bitmap read ports. A
// nearest query streams one node per cycle through the shared distance pipeline.
// A node read passes through the RISSUE, RS1 and RS2 states before its result.
// Configure only while idle.
module tile_walkable_node_table_nearest_unit #(
	parameter int MAX_COLS = 32,
	parameter int MAX_ROWS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         kind,
	input  wire logic [4:0]         cell_col,
	input  wire logic [4:0]         cell_row,
	input  wire logic               cell_solid,
	input  wire logic signed [15:0] query_x,
	input  wire logic signed [15:0] query_y,
	input  wire logic [9:0]         node_select,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [7:0]         cfg_data,
	output logic                    done,
	output logic [1:0]              status,
	output logic [10:0]             node_total,
	output logic [9:0]              found_index,
	output logic [4:0]              found_col,
	output logic [4:0]              found_row,
	output logic [13:0]             centre_x,
	output logic [13:0]             centre_y,
	output logic                    has_left,
	output logic [9:0]              left_index,
	output logic                    has_right,
	output logic [9:0]              right_index
);

	import twn_pkg::*;

	localparam int CLW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RLW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int AW   = CLW + RLW;
	localparam int NCW  = AW + 1;
	localparam int EW   = CLW + RLW + 1;
	localparam int CXW  = CLW + 9;
	localparam int CYW  = RLW + 9;
	localparam int DXW  = ((CXW > 16) ? CXW : 16) + 2;
	localparam int DYW  = ((CYW > 16) ? CYW : 16) + 2;
	localparam int SW   = 2 * ((DXW > DYW) ? DXW : DYW) + 1;
	localparam int SELW = (NCW > 10) ? NCW : 10;

	twn_state_t state_q, state_d;

	logic [5:0]  cols_q, rows_q, cols_eff, rows_eff;
	logic [7:0]  tp_q;
	logic [AW-1:0] clr_q;

	logic [5:0]  r_q, c_q;
	logic        build_last;
	logic        bv_s1, bbot_s1, bfirst_s1;
	logic [CLW-1:0] bcol_s1;
	logic [RLW-1:0] brow_s1;
	logic        prev_node_q, node_now;
	logic [NCW-1:0] count_q, count_d;

	logic [AW-1:0] i_q, qidx_s1;
	logic        qv_s1, qlast_s1, scan_last;
	logic signed [15:0] qx_q, qy_q;
	logic [SW-1:0] best_d_q;
	logic [AW-1:0] best_i_q, best_final;
	logic        have_best_q, upd;

	logic [AW-1:0] rpt_n_q;
	logic        rhl_q, rhr_q;

	logic        accept, in_range, dims_ok, sel_ok;

	logic        sw_en, sw_data, sra_data, srb_data;
	logic [AW-1:0] sw_addr, sra_addr, srb_addr;
	logic        nw_en;
	logic [AW-1:0] nw_addr, nra_addr, nrb_addr;
	logic [EW-1:0] nw_data, nra_data, nrb_data;

	logic [CLW-1:0] u_col;
	logic [RLW-1:0] u_row;
	logic [CXW-1:0] u_cx;
	logic [CYW-1:0] u_cy;
	logic        u_valid, u_last;
	logic [AW-1:0] u_tag;
	logic [SW-1:0] u_dist;

	logic        res_fire, res_node;
	logic [1:0]  res_status;
	logic [NCW-1:0] res_total;

	logic        done_q, hl_q, hr_q;
	logic [1:0]  status_q;
	logic [10:0] total_q;
	logic [9:0]  fidx_q, lidx_q, ridx_q;
	logic [4:0]  fcol_q, frow_q;
	logic [13:0] cx_q, cy_q;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// Saturate the grid size to the bitmap size
	assign cols_eff = ({3'b0, cols_q} > 9'(MAX_COLS)) ? 6'(MAX_COLS) : cols_q;
	assign rows_eff = ({3'b0, rows_q} > 9'(MAX_ROWS)) ? 6'(MAX_ROWS) : rows_q;
	assign dims_ok  = (cols_eff != 6'd0) && (rows_eff != 6'd0);
	assign in_range = ({4'b0, cell_col} < 9'(MAX_COLS)) && ({4'b0, cell_row} < 9'(MAX_ROWS));
	assign sel_ok   = (SELW'(node_select) < SELW'(count_q));

	assign build_last = ((r_q + 6'd1) == rows_eff) && ((c_q + 6'd1) == cols_eff);
	assign scan_last  = ((NCW'(i_q) + NCW'(1)) == count_q);

	// Node test on the cell and the cell below
	assign node_now = bv_s1 && !sra_data && (bbot_s1 || srb_data);
	assign count_d  = count_q + NCW'(node_now);

	// Keep the first strictly smaller distance
	assign upd        = u_valid && (!have_best_q || (u_dist < best_d_q));
	assign best_final = upd ? u_tag : best_i_q;

	twn_solid_map #(.AW(AW)) u_solid (
		.clk       (clk),
		.wr_en     (sw_en),
		.wr_addr   (sw_addr),
		.wr_data   (sw_data),
		.rd_a_addr (sra_addr),
		.rd_b_addr (srb_addr),
		.rd_a_data (sra_data),
		.rd_b_data (srb_data)
	);

	twn_node_store #(.AW(AW), .EW(EW)) u_nodes (
		.clk       (clk),
		.wr_en     (nw_en),
		.wr_addr   (nw_addr),
		.wr_data   (nw_data),
		.rd_a_addr (nra_addr),
		.rd_b_addr (nrb_addr),
		.rd_a_data (nra_data),
		.rd_b_data (nrb_data)
	);

	twn_dist_unit #(.CLW(CLW), .RLW(RLW), .TW(AW), .SW(SW)) u_dist_unit (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (qv_s1),
		.in_last   (qlast_s1),
		.in_tag    (qidx_s1),
		.in_col    (nra_data[EW-1 -: CLW]),
		.in_row    (nra_data[RLW:1]),
		.tile_px   (tp_q),
		.qx        (qx_q),
		.qy        (qy_q),
		.col_s2    (u_col),
		.row_s2    (u_row),
		.cx_s2     (u_cx),
		.cy_s2     (u_cy),
		.out_valid (u_valid),
		.out_last  (u_last),
		.out_tag   (u_tag),
		.out_dist  (u_dist)
	);

	// Node store write during the build scan
	assign nw_en   = node_now;
	assign nw_addr = count_q[AW-1:0];
	assign nw_data = {bcol_s1, brow_s1, (bfirst_s1 ? 1'b0 : prev_node_q)};

	// Next state, memory addresses and result selection
	always_comb begin
		state_d    = state_q;
		sw_en      = 1'b0;
		sw_addr    = {RLW'(cell_row), CLW'(cell_col)};
		sw_data    = cell_solid;
		sra_addr   = {RLW'(r_q), CLW'(c_q)};
		srb_addr   = {RLW'(r_q + 6'd1), CLW'(c_q)};
		nra_addr   = i_q;
		nrb_addr   = rpt_n_q + AW'(1);
		res_fire   = 1'b0;
		res_node   = 1'b0;
		res_status = STS_OK;
		res_total  = count_q;
		unique case (state_q)
			ST_CLEAR: begin
				sw_en   = 1'b1;
				sw_addr = clr_q;
				sw_data = 1'b0;
				if (&clr_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (kind)
						KIND_WRITE: begin
							sw_en    = in_range;
							res_fire = 1'b1;
						end
						KIND_BUILD: begin
							if (dims_ok) begin
								state_d = ST_BUILD;
							end else begin
								res_fire   = 1'b1;
								res_status = STS_EMPTY;
								res_total  = '0;
							end
						end
						KIND_QUERY: begin
							if (count_q != '0) begin
								state_d = ST_QSCAN;
							end else begin
								res_fire   = 1'b1;
								res_status = STS_EMPTY;
							end
						end
						KIND_READ: begin
							if (count_q == '0) begin
								res_fire   = 1'b1;
								res_status = STS_EMPTY;
							end else if (!sel_ok) begin
								res_fire   = 1'b1;
								res_status = STS_RANGE;
							end else begin
								state_d = ST_RISSUE;
							end
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_BUILD: begin
				if (build_last) begin
					state_d = ST_BDRAIN;
				end
			end
			ST_BDRAIN: begin
				state_d    = ST_IDLE;
				res_fire   = 1'b1;
				res_total  = count_d;
				res_status = (count_d == '0) ? STS_EMPTY : STS_OK;
			end
			ST_QSCAN: begin
				if (scan_last) begin
					state_d = ST_QDRAIN;
				end
			end
			ST_QDRAIN: begin
				if (u_valid && u_last) begin
					state_d = ST_RISSUE;
				end
			end
			ST_RISSUE: begin
				nra_addr = rpt_n_q;
				state_d  = ST_RS1;
			end
			ST_RS1: begin
				nra_addr = rpt_n_q;
				state_d  = ST_RS2;
			end
			ST_RS2: begin
				nra_addr = rpt_n_q;
				state_d  = ST_IDLE;
				res_fire = 1'b1;
				res_node = 1'b1;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cols_q      <= COLS_RST;
			rows_q      <= ROWS_RST;
			tp_q        <= TILE_RST;
			count_q     <= '0;
			prev_node_q <= 1'b0;
			bv_s1       <= 1'b0;
			qv_s1       <= 1'b0;
			have_best_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_fire;
			bv_s1   <= (state_q == ST_BUILD);
			qv_s1   <= (state_q == ST_QSCAN);

			// Take configuration transactions
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_COLS: cols_q <= cfg_data[5:0];
					CFG_ROWS: rows_q <= cfg_data[5:0];
					CFG_TILE: tp_q   <= cfg_data;
					default: begin
					end
				endcase
			end

			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end

			// Count nodes as the scan evaluates them
			if (bv_s1) begin
				prev_node_q <= node_now;
				count_q     <= count_d;
			end

			if (upd) begin
				have_best_q <= 1'b1;
			end

			if (accept && (kind == KIND_BUILD)) begin
				count_q     <= '0;
				prev_node_q <= 1'b0;
			end
			if (accept && (kind == KIND_QUERY)) begin
				have_best_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		bcol_s1   <= CLW'(c_q);
		brow_s1   <= RLW'(r_q);
		bbot_s1   <= ((r_q + 6'd1) >= rows_eff);
		bfirst_s1 <= (c_q == 6'd0);
		qidx_s1   <= i_q;
		qlast_s1  <= scan_last;

		// Advance the row-major scan
		if (state_q == ST_BUILD) begin
			if ((c_q + 6'd1) == cols_eff) begin
				c_q <= 6'd0;
				r_q <= r_q + 6'd1;
			end else begin
				c_q <= c_q + 6'd1;
			end
		end

		if (state_q == ST_QSCAN) begin
			i_q <= i_q + AW'(1);
		end

		if (upd) begin
			best_d_q <= u_dist;
			best_i_q <= u_tag;
		end

		if (accept) begin
			r_q  <= 6'd0;
			c_q  <= 6'd0;
			i_q  <= '0;
			qx_q <= query_x;
			qy_q <= query_y;
			rpt_n_q <= AW'(node_select);
		end

		if ((state_q == ST_QDRAIN) && u_valid && u_last) begin
			rpt_n_q <= best_final;
		end

		// Capture links of the reported node
		if (state_q == ST_RS1) begin
			rhl_q <= nra_data[0];
			rhr_q <= ((NCW'(rpt_n_q) + NCW'(1)) < count_q) && nrb_data[0];
		end

		// Hold the result for its one-cycle strobe
		if (res_fire) begin
			status_q <= res_status;
			total_q  <= 11'(res_total);
			if (res_node) begin
				fidx_q <= 10'(rpt_n_q);
				fcol_q <= 5'(u_col);
				frow_q <= 5'(u_row);
				cx_q   <= 14'(u_cx);
				cy_q   <= 14'(u_cy);
				hl_q   <= rhl_q;
				lidx_q <= rhl_q ? 10'(rpt_n_q - AW'(1)) : 10'd0;
				hr_q   <= rhr_q;
				ridx_q <= rhr_q ? 10'(rpt_n_q + AW'(1)) : 10'd0;
			end else begin
				fidx_q <= 10'd0;
				fcol_q <= 5'd0;
				frow_q <= 5'd0;
				cx_q   <= 14'd0;
				cy_q   <= 14'd0;
				hl_q   <= 1'b0;
				lidx_q <= 10'd0;
				hr_q   <= 1'b0;
				ridx_q <= 10'd0;
			end
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign node_total  = total_q;
	assign found_index = fidx_q;
	assign found_col   = fcol_q;
	assign found_row   = frow_q;
	assign centre_x    = cx_q;
	assign centre_y    = cy_q;
	assign has_left    = hl_q;
	assign left_index  = lidx_q;
	assign has_right   = hr_q;
	assign right_index = ridx_q;

endmodule
`default_nettype wire

>>> verif/tile_walkable_node_table_nearest_unit_tb.sv
`default_nettype none
module tile_walkable_node_table_nearest_unit_tb;
	import twn_pkg::*;

	localparam int GRID_W      = 32;
	localparam int GRID_H      = 32;
	localparam int CELL_COUNT  = GRID_W * GRID_H;
	localparam int STALL_LIMIT = 20000;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 58;

	typedef struct {
		logic [1:0]  kind;
		logic [4:0]  col;
		logic [4:0]  row;
		logic        solid;
		logic [15:0] qx;
		logic [15:0] qy;
		logic [9:0]  sel;
	} tile_item_t;

	typedef struct {
		logic [1:0]  status;
		logic [10:0] total;
		logic [9:0]  index;
		logic [4:0]  col;
		logic [4:0]  row;
		logic [13:0] cx;
		logic [13:0] cy;
		logic        hl;
		logic [9:0]  li;
		logic        hr;
		logic [9:0]  ri;
	} node_result_t;

	// One directed row: a config write or an item, with an optional typed expectation
	typedef struct {
		bit          is_cfg;
		logic [1:0]  cfg_idx;
		logic [7:0]  cfg_val;
		tile_item_t  item;
		bit          typed;
		logic [1:0]  status;
		logic [10:0] total;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] kind = KIND_WRITE;
	logic [4:0] cell_col = '0;
	logic [4:0] cell_row = '0;
	logic cell_solid = 1'b0;
	logic signed [15:0] query_x = '0;
	logic signed [15:0] query_y = '0;
	logic [9:0] node_select = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = CFG_COLS;
	logic [7:0] cfg_data = '0;
	logic done;
	logic [1:0] status;
	logic [10:0] node_total;
	logic [9:0] found_index;
	logic [4:0] found_col;
	logic [4:0] found_row;
	logic [13:0] centre_x;
	logic [13:0] centre_y;
	logic has_left;
	logic [9:0] left_index;
	logic has_right;
	logic [9:0] right_index;

	tile_walkable_node_table_nearest_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.cell_col(cell_col), .cell_row(cell_row), .cell_solid(cell_solid),
		.query_x(query_x), .query_y(query_y), .node_select(node_select),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .status(status), .node_total(node_total),
		.found_index(found_index), .found_col(found_col), .found_row(found_row),
		.centre_x(centre_x), .centre_y(centre_y), .has_left(has_left),
		.left_index(left_index), .has_right(has_right), .right_index(right_index)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the block state
	logic [5:0]  sh_cols = COLS_RST;
	logic [5:0]  sh_rows = ROWS_RST;
	logic [7:0]  sh_tile = TILE_RST;
	bit          sh_solid [CELL_COUNT];
	int          sh_cell_node [CELL_COUNT];
	int          sh_node_cell [CELL_COUNT];
	logic [21:0] sh_links [CELL_COUNT];
	int          sh_count = 0;

	node_result_t pending_results [$];
	int fail_count = 0;
	int stall_cycles = 0;
	bit burst_mode = 1'b0;

	function automatic int clamp_dim(logic [5:0] v, int lim);
		return (v > lim) ? lim : int'(v);
	endfunction

	// Rescan the bitmap and relink the walkable nodes
	function automatic void rebuild_nodes();
		int cols;
		int rows;
		int cell_id;
		int c0;
		logic [21:0] lk;
		cols = clamp_dim(sh_cols, GRID_W);
		rows = clamp_dim(sh_rows, GRID_H);
		foreach (sh_cell_node[i]) sh_cell_node[i] = 0;
		sh_count = 0;
		for (int r = 0; r < rows; r++) begin
			for (int c = 0; c < cols; c++) begin
				cell_id = r * GRID_W + c;
				if (sh_solid[cell_id]) continue;
				if (r + 1 < rows && !sh_solid[cell_id + GRID_W]) continue;
				sh_node_cell[sh_count] = cell_id;
				sh_count++;
				sh_cell_node[cell_id] = sh_count;
			end
		end
		for (int i = 0; i < sh_count; i++) begin
			cell_id = sh_node_cell[i];
			c0 = cell_id % GRID_W;
			lk = '0;
			if (c0 > 0 && sh_cell_node[cell_id - 1] != 0) begin
				lk[21] = 1'b1;
				lk[20:11] = 10'(sh_cell_node[cell_id - 1] - 1);
			end
			if (c0 + 1 < cols && sh_cell_node[cell_id + 1] != 0) begin
				lk[10] = 1'b1;
				lk[9:0] = 10'(sh_cell_node[cell_id + 1] - 1);
			end
			sh_links[i] = lk;
		end
	endfunction

	function automatic void fill_node(int idx, ref node_result_t res);
		int cell_id;
		cell_id = sh_node_cell[idx];
		res.index = 10'(idx);
		res.col = 5'(cell_id % GRID_W);
		res.row = 5'(cell_id / GRID_W);
		res.cx = 14'((2 * (cell_id % GRID_W) + 1) * int'(sh_tile));
		res.cy = 14'((2 * (cell_id / GRID_W) + 1) * int'(sh_tile));
		res.hl = sh_links[idx][21];
		res.li = sh_links[idx][20:11];
		res.hr = sh_links[idx][10];
		res.ri = sh_links[idx][9:0];
	endfunction

	// Lowest squared distance from the point to a node centre, ties to lower index
	function automatic int closest_node(logic signed [15:0] qx, logic signed [15:0] qy);
		int best;
		int cell_id;
		longint dx;
		longint dy;
		longint d;
		longint best_d;
		best = 0;
		best_d = -1;
		for (int i = 0; i < sh_count; i++) begin
			cell_id = sh_node_cell[i];
			dx = longint'((2 * (cell_id % GRID_W) + 1) * int'(sh_tile)) - longint'(qx);
			dy = longint'((2 * (cell_id / GRID_W) + 1) * int'(sh_tile)) - longint'(qy);
			d = dx * dx + dy * dy;
			if (best_d < 0 || d < best_d) begin
				best_d = d;
				best = i;
			end
		end
		return best;
	endfunction

	function automatic node_result_t node_table_step(tile_item_t it);
		node_result_t res;
		res = '{default: '0};
		case (it.kind)
			KIND_WRITE: sh_solid[int'(it.row) * GRID_W + int'(it.col)] = it.solid;
			KIND_BUILD: begin
				rebuild_nodes();
				if (sh_count == 0) res.status = STS_EMPTY;
			end
			KIND_QUERY: begin
				if (sh_count == 0) res.status = STS_EMPTY;
				else fill_node(closest_node(it.qx, it.qy), res);
			end
			default: begin
				if (sh_count == 0) res.status = STS_EMPTY;
				else if (int'(it.sel) >= sh_count) res.status = STS_RANGE;
				else fill_node(int'(it.sel), res);
			end
		endcase
		res.total = 11'(sh_count);
		return res;
	endfunction

	task automatic check_field(string name, int e, int a);
		if (e != a) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, e, a);
			fail_count++;
		end
	endtask

	// Compare each strobed result with the oldest expectation
	always @(posedge clk) begin
		node_result_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual status %0d",
					$time, status);
				fail_count++;
			end else begin
				e = pending_results.pop_front();
				check_field("status", e.status, status);
				check_field("node_total", e.total, node_total);
				check_field("found_index", e.index, found_index);
				check_field("found_col", e.col, found_col);
				check_field("found_row", e.row, found_row);
				check_field("centre_x", e.cx, centre_x);
				check_field("centre_y", e.cy, centre_y);
				check_field("has_left", e.hl, has_left);
				check_field("left_index", e.li, left_index);
				check_field("has_right", e.hr, has_right);
				check_field("right_index", e.ri, right_index);
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tile_walkable_node_table_nearest_unit_tb: FAIL");
			$finish;
		end
	end

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] val);
		wait_drained();
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_COLS: sh_cols = val[5:0];
			CFG_ROWS: sh_rows = val[5:0];
			default:  sh_tile = val;
		endcase
	endtask

	// Hold start until the block takes the transaction, then idle a random gap outside burst mode
	task automatic send_item(tile_item_t it, bit typed, logic [1:0] st, logic [10:0] tot);
		node_result_t res;
		int gap;
		kind <= it.kind;
		cell_col <= it.col;
		cell_row <= it.row;
		cell_solid <= it.solid;
		query_x <= it.qx;
		query_y <= it.qy;
		node_select <= it.sel;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		res = node_table_step(it);
		if (typed) begin
			res = '{default: '0};
			res.status = st;
			res.total = tot;
		end
		pending_results = {pending_results, res};
		gap = burst_mode ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic tile_item_t mk(logic [1:0] k, int c, int r, bit s, int qx, int qy,
		int sel);
		tile_item_t it;
		it.kind = k;
		it.col = 5'(c);
		it.row = 5'(r);
		it.solid = s;
		it.qx = 16'(qx);
		it.qy = 16'(qy);
		it.sel = 10'(sel);
		return it;
	endfunction

	function automatic directed_row_t cfg_row(logic [1:0] idx, logic [7:0] val);
		directed_row_t d;
		d = '{default: '0};
		d.is_cfg = 1'b1;
		d.cfg_idx = idx;
		d.cfg_val = val;
		return d;
	endfunction

	function automatic directed_row_t item_row(tile_item_t it, bit typed, logic [1:0] st,
		int tot);
		directed_row_t d;
		d = '{default: '0};
		d.item = it;
		d.typed = typed;
		d.status = st;
		d.total = 11'(tot);
		return d;
	endfunction

	function automatic tile_item_t random_item();
		int cols;
		int rows;
		int pick;
		int span;
		tile_item_t it;
		cols = clamp_dim(sh_cols, GRID_W);
		rows = clamp_dim(sh_rows, GRID_H);
		if (cols == 0) cols = 1;
		if (rows == 0) rows = 1;
		it = mk(KIND_WRITE, $urandom, $urandom, 1'($urandom), $urandom, $urandom, $urandom);
		pick = $urandom_range(0, 99);
		span = 2 * cols * int'(sh_tile) + 64;
		if (pick < 55) begin
			// keep most writes inside the active area
			if ($urandom_range(0, 9) != 0) begin
				it.col = 5'($urandom_range(0, cols - 1));
				it.row = 5'($urandom_range(0, rows - 1));
			end
		end else if (pick < 66) begin
			it.kind = KIND_BUILD;
		end else if (pick < 83) begin
			it.kind = KIND_QUERY;
			if ($urandom_range(0, 1)) begin
				it.qx = 16'($urandom_range(0, span) - 32);
				it.qy = 16'($urandom_range(0, 2 * rows * int'(sh_tile) + 64) - 32);
			end
		end else begin
			it.kind = KIND_READ;
			if (sh_count > 0 && $urandom_range(0, 4) != 0)
				it.sel = 10'($urandom_range(0, sh_count - 1));
		end
		return it;
	endfunction

	function automatic logic [7:0] random_dim();
		case ($urandom_range(0, 9))
			0: return 8'd32;
			1: return 8'd63;
			2: return 8'd1;
			3: return 8'd0;
			default: return 8'($urandom_range(2, 8));
		endcase
	endfunction

	initial begin
		directed_row_t plan [$];
		logic [7:0] v;
		// Reset extremes, range errors, ties and config corners
		plan = {plan, item_row(mk(KIND_QUERY, 0, 0, 0, 0, 0, 0), 1, STS_EMPTY, 0)};
		plan = {plan, item_row(mk(KIND_READ, 0, 0, 0, 0, 0, 0), 1, STS_EMPTY, 0)};
		plan = {plan, item_row(mk(KIND_BUILD, 0, 0, 0, 0, 0, 0), 1, STS_OK, 32)};
		plan = {plan, item_row(mk(KIND_READ, 0, 0, 0, 0, 0, 1023), 1, STS_RANGE, 32)};
		plan = {plan, item_row(mk(KIND_READ, 0, 0, 0, 0, 0, 32), 1, STS_RANGE, 32)};
		plan = {plan, item_row(mk(KIND_READ, 0, 0, 0, 0, 0, 0), 0, STS_OK, 0)};
		plan = {plan, item_row(mk(KIND_READ, 0, 0, 0, 0, 0, 31), 0, STS_OK, 0)};
		plan = {plan, item_row(mk(KIND_QUERY, 0, 0, 0, -32768, -32768, 0), 0, STS_OK, 0)};
		plan = {plan, item_row(mk(KIND_QUERY, 0, 0, 0, 32767, 32767, 0), 0, STS_OK, 0)};
		plan = {plan, item_row(mk(KIND_QUERY, 0, 0, 0, 64, 2016, 0), 0, STS_OK, 0)};
		plan = {plan, item_row(mk(KIND_WRITE, 31, 31, 1, 0, 0, 0), 1, STS_OK, 32)};
		plan = {plan, item_row(mk(KIND_WRITE, 0, 30, 1, 0, 0, 0), 1, STS_OK, 32)};
		plan = {plan, item_row(mk(KIND_BUILD, 0, 0, 0, 0, 0, 0), 0, STS_OK, 0)};
		plan = {plan, item_row(mk(KIND_READ, 0, 0, 0, 0, 0, 30), 0, STS_OK, 0)};
		plan = {plan, cfg_row(CFG_COLS, 8'd0)};
		plan = {plan, item_row(mk(KIND_BUILD, 0, 0, 0, 0, 0, 0), 1, STS_EMPTY, 0)};
		plan = {plan, item_row(mk(KIND_READ, 0, 0, 0, 0, 0, 5), 1, STS_EMPTY, 0)};
		plan = {plan, cfg_row(CFG_COLS, 8'hFF)};
		plan = {plan, cfg_row(CFG_ROWS, 8'hFF)};
		plan = {plan, cfg_row(CFG_TILE, 8'd255)};
		plan = {plan, item_row(mk(KIND_BUILD, 0, 0, 0, 0, 0, 0), 0, STS_OK, 0)};
		plan = {plan, item_row(mk(KIND_QUERY, 0, 0, 0, 32767, -1, 0), 0, STS_OK, 0)};
		plan = {plan, cfg_row(CFG_TILE, 8'd0)};
		plan = {plan, item_row(mk(KIND_QUERY, 0, 0, 0, 100, 100, 0), 0, STS_OK, 0)};
		plan = {plan, cfg_row(CFG_ROWS, 8'd1)};
		plan = {plan, cfg_row(CFG_TILE, 8'd1)};
		plan = {plan, item_row(mk(KIND_BUILD, 0, 0, 0, 0, 0, 0), 0, STS_OK, 0)};
		plan = {plan, item_row(mk(KIND_READ, 0, 0, 0, 0, 0, 31), 0, STS_OK, 0)};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) write_reg(plan[i].cfg_idx, plan[i].cfg_val);
			else send_item(plan[i].item, plan[i].typed, plan[i].status, plan[i].total);
		end

		// Random phases, each under its own configuration
		for (int p = 0; p < PHASES; p++) begin
			v = random_dim();
			write_reg(CFG_COLS, {2'($urandom), v[5:0]});
			v = random_dim();
			write_reg(CFG_ROWS, {2'($urandom), v[5:0]});
			case ($urandom_range(0, 5))
				0: v = 8'd0;
				1: v = 8'd255;
				default: v = 8'($urandom);
			endcase
			write_reg(CFG_TILE, v);
			burst_mode = (p % 3 == 1);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_item(random_item(), 1'b0, STS_OK, 11'd0);
				// drain everything once in mid phase
				if (n == PHASE_ITEMS / 2 && p == 2) wait_drained();
			end
		end

		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("tile_walkable_node_table_nearest_unit_tb: PASS");
		end else begin
			$display("tile_walkable_node_table_nearest_unit_tb: FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire
